[hdl/lpt_pkg.sv]
`default_nettype none

package lpt_pkg;

  // Default sizes of the table
  localparam int PAGES_DEF    = 8;
  localparam int ID_WIDTH_DEF = 8;

  // Fixed port widths
  localparam int PAGE_ID_W = 8;
  localparam int SLOT_W    = 3;
  localparam int FILL_W    = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming page id
    logic search;  // compare against all slots, pick the target slot
    logic commit;  // update ranks and pages, load the output word
  } cmd_t;

endpackage

`default_nettype wire

[hdl/lpt_ctrl.sv]
`default_nettype none

module lpt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output lpt_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode commands
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.search = (state_r == S_LOOK);
    cmd.commit = (state_r == S_UPDATE) && (!out_valid_r || out_ready);
  end

  // Advance the sequence; hold in update while the output word is not yet taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_UPDATE;
      S_UPDATE: if (cmd.commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Output word valid: set on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/lpt_datapath.sv]
`default_nettype none

module lpt_datapath #(
  parameter int PAGES    = lpt_pkg::PAGES_DEF,
  parameter int ID_WIDTH = lpt_pkg::ID_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lpt_pkg::cmd_t                 cmd,
  input  wire logic [lpt_pkg::PAGE_ID_W-1:0] in_page_id,
  output logic                               out_hit,
  output logic [lpt_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted_valid,
  output logic [lpt_pkg::PAGE_ID_W-1:0]      out_evicted_page,
  output logic [lpt_pkg::FILL_W-1:0]         out_fill_count
);

  localparam int IDX_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CNT_W  = $clog2(PAGES + 1);
  localparam int RANK_W = IDX_W;
  localparam int KEY_W  = (ID_WIDTH < lpt_pkg::PAGE_ID_W) ? ID_WIDTH : lpt_pkg::PAGE_ID_W;

  // Table state
  logic [KEY_W-1:0]  page_r [PAGES];
  logic [RANK_W-1:0] rank_r [PAGES];
  logic [RANK_W-1:0] rank_nxt [PAGES];
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  // Lookup results
  logic [KEY_W-1:0]  id_r;
  logic              hit_r, full_r;
  logic [IDX_W-1:0]  slot_r;
  logic [PAGES-1:0]  sel_oh_r;
  logic [RANK_W-1:0] old_rank_r;
  logic [KEY_W-1:0]  ev_page_r;

  // Output word
  logic                          out_hit_r;
  logic [lpt_pkg::SLOT_W-1:0]    out_slot_r;
  logic                          out_ev_valid_r;
  logic [lpt_pkg::PAGE_ID_W-1:0] out_ev_page_r;
  logic [lpt_pkg::FILL_W-1:0]    out_fill_r;

  // Search logic
  logic [PAGES-1:0]  match, victim, sel_oh;
  logic              hit, full;
  logic [IDX_W-1:0]  mslot, vslot, sel_slot;
  logic [RANK_W-1:0] old_rank;
  logic [KEY_W-1:0]  ev_page;

  // Capture the page id, masked to the key width
  always_ff @(posedge clk) begin
    if (cmd.load) id_r <= KEY_W'(in_page_id);
  end

  // Compare every occupied slot; the least recent slot carries the top rank
  always_comb begin
    for (int i = 0; i < PAGES; i++) begin
      match[i]  = (CNT_W'(i) < occ_r) && (page_r[i] == id_r);
      victim[i] = (rank_r[i] == RANK_W'(PAGES - 1));
    end
    hit  = |match;
    full = (occ_r == CNT_W'(PAGES));
  end

  // Pick the lowest matching slot and the lowest victim slot
  always_comb begin
    mslot = '0;
    vslot = '0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      if (match[i])  mslot = IDX_W'(i);
      if (victim[i]) vslot = IDX_W'(i);
    end
    priority if (hit) sel_slot = mslot;
    else if (full)    sel_slot = vslot;
    else              sel_slot = occ_r[IDX_W-1:0];
  end

  // Read the old rank and the old page of the chosen slot
  always_comb begin
    old_rank = '0;
    ev_page  = '0;
    for (int i = 0; i < PAGES; i++) begin
      sel_oh[i] = (IDX_W'(i) == sel_slot);
      old_rank  = old_rank | (rank_r[i] & {RANK_W{sel_oh[i]}});
      ev_page   = ev_page  | (page_r[i] & {KEY_W{sel_oh[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r      <= hit;
      full_r     <= full;
      slot_r     <= sel_slot;
      sel_oh_r   <= sel_oh;
      old_rank_r <= old_rank;
      ev_page_r  <= ev_page;
    end
  end

  // Age the entries more recent than the touched one (every occupied entry on a miss), touched one goes to rank zero
  always_comb begin
    for (int i = 0; i < PAGES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (sel_oh_r[i]) begin
        rank_nxt[i] = '0;
      end else if ((CNT_W'(i) < occ_r) && (!hit_r || (rank_r[i] < old_rank_r))) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
    occ_nxt = occ_r;
    if (!hit_r && !full_r) occ_nxt = occ_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) rank_r[i] <= '0;
      occ_r <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < PAGES; i++) rank_r[i] <= rank_nxt[i];
      occ_r <= occ_nxt;
    end
  end

  // Write the new page into the chosen slot on a miss
  always_ff @(posedge clk) begin
    for (int i = 0; i < PAGES; i++) begin
      if (cmd.commit && !hit_r && sel_oh_r[i]) page_r[i] <= id_r;
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r      <= hit_r;
      out_slot_r     <= lpt_pkg::SLOT_W'(slot_r);
      out_ev_valid_r <= !hit_r && full_r;
      out_ev_page_r  <= (!hit_r && full_r) ? lpt_pkg::PAGE_ID_W'(ev_page_r) : '0;
      out_fill_r     <= lpt_pkg::FILL_W'(occ_nxt);
    end
  end

  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fill_count    = out_fill_r;

endmodule

`default_nettype wire

[hdl/lru_page_table_top.sv]
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   -------------------------------------------
// input     in_valid / in_ready     in_page_id
// result    out_valid / out_ready   out_hit, out_slot, out_evicted_valid,
//                                   out_evicted_page, out_fill_count
//
// One word passes three steps: accept, parallel tag compare, rank/page update.
// The compare over all slots and the rank update each get a state of their own.
// A new word is accepted once the previous one has been written to the output
// register, even while that result still waits for out_ready.
// The update step holds while the output register is full and not taken.
// Synchronous reset empties the table at once; no clearing pass is needed.

module lru_page_table_top #(
  parameter int PAGES    = lpt_pkg::PAGES_DEF,
  parameter int ID_WIDTH = lpt_pkg::ID_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lpt_pkg::PAGE_ID_W-1:0] in_page_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [lpt_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted_valid,
  output logic [lpt_pkg::PAGE_ID_W-1:0]      out_evicted_page,
  output logic [lpt_pkg::FILL_W-1:0]         out_fill_count
);

  lpt_pkg::cmd_t cmd;

  lpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lpt_datapath #(
    .PAGES    (PAGES),
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_id        (in_page_id),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fill_count    (out_fill_count)
  );

  // A hit never evicts
  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("eviction reported on a hit");

  // Eviction only happens with a full table
  a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> (out_fill_count == lpt_pkg::FILL_W'(PAGES)))
    else $error("eviction with free slots left");

  // No evicted page without eviction
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  // One word in flight: input closes after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = lpt_pkg::PAGES_DEF;
  localparam int ID_BITS   = lpt_pkg::ID_WIDTH_DEF;
  localparam logic [lpt_pkg::PAGE_ID_W-1:0] ID_MASK =
    lpt_pkg::PAGE_ID_W'((64'd1 << ID_BITS) - 64'd1);

  typedef logic [lpt_pkg::PAGE_ID_W-1:0] page_t;

  // One lookup outcome, as the result channel carries it
  typedef struct packed {
    logic                      hit;
    logic [lpt_pkg::SLOT_W-1:0] slot;
    logic                      ev_valid;
    page_t                     ev_page;
    logic [lpt_pkg::FILL_W-1:0] fill;
  } lookup_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  page_t in_page_id;
  logic  out_valid;
  logic  out_ready;
  logic  out_hit;
  logic [lpt_pkg::SLOT_W-1:0] out_slot;
  logic  out_evicted_valid;
  page_t out_evicted_page;
  logic [lpt_pkg::FILL_W-1:0] out_fill_count;

  // Shadow copy of the page table
  page_t    tbl_page [NUM_SLOTS];
  int       tbl_rank [NUM_SLOTS];
  int       tbl_fill;

  lookup_t  pending_results[$];
  bit       allow_idle = 1'b1;
  int       err_count;
  int       sent_count;
  int       hit_count;
  int       evict_count;
  int       checked_count;

  lru_page_table_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_id       (in_page_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fill_count   (out_fill_count)
  );

  always #1 clk = ~clk;

  // Promote one slot to most recent; entries more recent than old_rank age by one
  function automatic void promote_slot(input int slot, input int old_rank);
    for (int i = 0; i < tbl_fill; i++) begin
      if (i != slot && tbl_rank[i] < old_rank) tbl_rank[i]++;
    end
    tbl_rank[slot] = 0;
  endfunction

  // Look up one page in the shadow table and update it as the block should
  function automatic lookup_t lookup_page(input page_t raw_id);
    lookup_t r;
    page_t   id;
    int      best;
    id = raw_id & ID_MASK;
    r = '0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (!r.hit && tbl_page[i] == id) begin
        r.hit  = 1'b1;
        r.slot = lpt_pkg::SLOT_W'(i);
      end
    end
    if (r.hit) begin
      promote_slot(int'(r.slot), tbl_rank[r.slot]);
    end else if (tbl_fill < NUM_SLOTS) begin
      r.slot = lpt_pkg::SLOT_W'(tbl_fill);
      tbl_page[tbl_fill] = id;
      tbl_fill++;
      promote_slot(tbl_fill - 1, NUM_SLOTS);
    end else begin
      // full table: replace the oldest entry, lowest slot on a tie
      best = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (tbl_rank[i] > tbl_rank[best]) best = i;
      end
      r.slot     = lpt_pkg::SLOT_W'(best);
      r.ev_valid = 1'b1;
      r.ev_page  = tbl_page[best];
      tbl_page[best] = id;
      promote_slot(best, NUM_SLOTS);
    end
    r.fill = lpt_pkg::FILL_W'(tbl_fill);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Send one page word; may hold off first with a random idle burst
  task automatic send_page(input page_t id);
    lookup_t r;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid   <= 1'b0;
      in_page_id <= page_t'($urandom_range(0, 255));
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_page_id <= id;
    do @(posedge clk); while (!in_ready);
    r = lookup_page(id);
    pending_results.push_back(r);
    sent_count++;
    if (r.hit) hit_count++;
    if (r.ev_valid) evict_count++;
    @(negedge clk);
  endtask

  // Receiver: alternate stall bursts and ready stretches; only ready stretches once idles are off
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (allow_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result word with nothing outstanding", $realtime);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_hit !== want.hit) flag_mismatch("hit", int'(out_hit), int'(want.hit));
        if (out_slot !== want.slot)
          flag_mismatch("slot", int'(out_slot), int'(want.slot));
        if (out_evicted_valid !== want.ev_valid)
          flag_mismatch("evicted_valid", int'(out_evicted_valid), int'(want.ev_valid));
        if (out_evicted_page !== want.ev_page)
          flag_mismatch("evicted_page", int'(out_evicted_page), int'(want.ev_page));
        if (out_fill_count !== want.fill)
          flag_mismatch("fill_count", int'(out_fill_count), int'(want.fill));
      end
    end
  end

  // Fill an empty table with the extreme ids, then hit, evict and re-miss
  task automatic test_fill_hit_evict();
    page_t ids[$];
    ids = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
            8'h00, 8'hFE, 8'h80, 8'h10, 8'h20, 8'h10, 8'hFF, 8'h00,
            8'hAA, 8'h7F};
    foreach (ids[i]) send_page(ids[i]);
  endtask

  // Small working set drifting over the id space: mix of hits and evictions
  task automatic test_working_set(input int count);
    page_t base;
    base = page_t'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) base = page_t'($urandom_range(0, 255));
      send_page(page_t'(base + page_t'($urandom_range(0, 10))));
    end
  endtask

  // Fully random ids: mostly misses on a full table
  task automatic test_random_ids(input int count);
    for (int n = 0; n < count; n++) send_page(page_t'($urandom_range(0, 255)));
  endtask

  // Cycle through one more page than the table holds: after the first pass every access evicts
  task automatic test_cyclic_thrash(input int count);
    page_t base;
    base = page_t'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) send_page(page_t'(base + page_t'(n % (NUM_SLOTS + 1))));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_page_id = '0;
    tbl_fill   = 0;
    foreach (tbl_rank[i]) begin
      tbl_rank[i] = 0;
      tbl_page[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_fill_hit_evict();
    test_working_set(250);
    test_random_ids(150);
    test_cyclic_thrash(50);

    // last stretch runs back to back on both sides
    allow_idle = 1'b0;
    test_working_set(100);
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d lookups sent, %0d results checked", sent_count, checked_count);
    $display("%0d hits, %0d evictions, %0d errors", hit_count, evict_count, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
